>>> sv/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, sizes and codes of the banker's safety check engine.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int MAX_PROCS   = 8;
  localparam int MAX_RES     = 8;
  localparam int COUNT_WIDTH = 8;
  localparam int WORK_WIDTH  = COUNT_WIDTH + 4;
  localparam int PROC_IDX_W  = 3;
  localparam int RES_IDX_W   = 3;
  localparam int CFG_W       = 4;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [WORK_WIDTH-1:0]  work_t;
  typedef count_t [MAX_RES-1:0]   row_t;

  typedef enum logic [1:0] {
    MODE_LOAD_AVAIL = 2'd0,
    MODE_LOAD_CLAIM = 2'd1,
    MODE_REQUEST    = 2'd2,
    MODE_QUERY      = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    STS_ACCEPTED   = 3'd0,
    STS_GRANTED    = 3'd1,
    STS_REJ_LIMIT  = 3'd2,
    STS_REJ_UNSAFE = 3'd3,
    STS_SAFE       = 3'd4,
    STS_UNSAFE     = 3'd5,
    STS_BAD_LOAD   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SW_INIT,
    S_SW_READ,
    S_SW_CMP,
    S_SW_END,
    S_DONE
  } state_e;

  localparam logic REG_PROCS = 1'b0;
  localparam logic REG_RES   = 1'b1;

  typedef struct packed {
    logic accept;
    logic check;
    logic sw_init;
    logic sw_cmp;
    logic sw_end;
  } cmd_t;

  typedef struct packed {
    logic req_ok;
    logic np_zero;
    logic last_proc;
    logic sweep_more;
  } sts_t;

endpackage

>>> sv/bsc_ctrl.sv
// ----------------------------------------------------------------------------
// bsc_ctrl
// Sequencer: request check, safety sweep passes, rollback and result hand-off.
// ----------------------------------------------------------------------------
module bsc_ctrl import bsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_mode_i,
  input  logic       in_last_i,
  input  logic       out_free_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       in_ready_o,
  output logic       out_load_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_mode_i == MODE_QUERY) state_d = S_SW_INIT;
          else if (in_mode_i == MODE_REQUEST && in_last_i) state_d = S_CHECK;
          else state_d = S_DONE;
        end
      end
      S_CHECK:   state_d = sts_i.req_ok ? S_SW_INIT : S_DONE;
      S_SW_INIT: state_d = sts_i.np_zero ? S_SW_END : S_SW_READ;
      S_SW_READ: state_d = S_SW_CMP;
      S_SW_CMP: begin
        if (sts_i.last_proc && !sts_i.sweep_more) state_d = S_SW_END;
        else state_d = S_SW_READ;
      end
      S_SW_END:  state_d = S_DONE;
      S_DONE:    if (out_free_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    out_load_o = 1'b0;
    unique case (state_q)
      S_IDLE:    cmd_o.accept  = accept;
      S_CHECK:   cmd_o.check   = 1'b1;
      S_SW_INIT: cmd_o.sw_init = 1'b1;
      S_SW_READ: ;
      S_SW_CMP:  cmd_o.sw_cmp  = 1'b1;
      S_SW_END:  cmd_o.sw_end  = 1'b1;
      S_DONE:    out_load_o    = out_free_i;
      default:   ;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_query_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_mode_i == MODE_QUERY) |=> state_q == S_SW_INIT)
    else $error("query did not start a sweep");

  a_read_then_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SW_READ) |=> state_q == S_SW_CMP)
    else $error("row read not followed by compare");

  a_done_hands_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free_i) |=> state_q == S_IDLE)
    else $error("result hand-off stalled");

endmodule

>>> sv/bsc_dpath.sv
// ----------------------------------------------------------------------------
// bsc_dpath
// Stores (available, allocation and need rows, request buffer), the request
// check, and the work vector of the safety sweep.
// ----------------------------------------------------------------------------
module bsc_dpath import bsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic [1:0]            mode_i,
  input  logic [PROC_IDX_W-1:0] process_i,
  input  logic [RES_IDX_W-1:0]  resource_i,
  input  count_t                amount_i,
  input  count_t                held_i,
  input  logic [CFG_W-1:0]      np_i,
  input  logic [CFG_W-1:0]      nr_i,
  output sts_t                  sts_o,
  output logic [2:0]            status_o,
  output logic [3:0]            count_o
);

  count_t avail_q [MAX_RES];
  count_t req_q   [MAX_RES];
  work_t  work_q  [MAX_RES];
  row_t   save_alloc_q, save_need_q;
  logic [MAX_PROCS-1:0] marks_q;
  logic [3:0]           done_q;
  logic                 progress_q;
  logic [PROC_IDX_W-1:0] p_q, proc_q;
  logic                 query_q;
  logic [2:0]           status_q;
  logic [3:0]           count_q;

  row_t mem_alloc [MAX_PROCS];
  row_t mem_need  [MAX_PROCS];
  logic [MAX_RES-1:0] valid_q [MAX_PROCS];
  row_t rd_alloc_q, rd_need_q;
  logic [MAX_RES-1:0] rd_valid_q;

  row_t alloc_row, need_row, walloc, wneed;
  logic [MAX_RES-1:0] in_use, we;
  logic [PROC_IDX_W-1:0] raddr, waddr;
  logic req_ok, fits, progress_d, rollback, load_ok;
  logic [3:0] done_d;

  always_comb begin
    for (int e = 0; e < MAX_RES; e++) begin
      alloc_row[e] = rd_valid_q[e] ? rd_alloc_q[e] : '0;
      need_row[e]  = rd_valid_q[e] ? rd_need_q[e]  : '0;
      in_use[e]    = (CFG_W'(e) < nr_i);
    end
  end

  always_comb begin
    req_ok = ({1'b0, proc_q} < np_i);
    fits   = !marks_q[p_q];
    for (int e = 0; e < MAX_RES; e++) begin
      if (in_use[e] && (req_q[e] > need_row[e] || req_q[e] > avail_q[e])) req_ok = 1'b0;
      if (in_use[e] && (WORK_WIDTH'(need_row[e]) > work_q[e])) fits = 1'b0;
    end
  end

  assign done_d     = done_q + {3'b0, fits};
  assign progress_d = progress_q | fits;
  assign rollback   = cmd_i.sw_end && !query_q && (done_q != np_i);
  assign load_ok    = (held_i <= amount_i);

  assign sts_o.req_ok     = req_ok;
  assign sts_o.np_zero    = (np_i == '0);
  assign sts_o.last_proc  = ({1'b0, p_q} == np_i - 4'd1);
  assign sts_o.sweep_more = (done_d < np_i) && progress_d;

  assign raddr = cmd_i.accept ? process_i : p_q;

  // write port: one element on a load, whole row on apply or rollback
  always_comb begin
    we     = '0;
    waddr  = proc_q;
    walloc = alloc_row;
    wneed  = need_row;
    if (cmd_i.accept && mode_i == MODE_LOAD_CLAIM && load_ok) begin
      waddr          = process_i;
      we[resource_i] = 1'b1;
      for (int e = 0; e < MAX_RES; e++) begin
        walloc[e] = held_i;
        wneed[e]  = amount_i - held_i;
      end
    end else if (cmd_i.check && req_ok) begin
      we = '1;
      for (int e = 0; e < MAX_RES; e++) begin
        if (in_use[e]) begin
          walloc[e] = alloc_row[e] + req_q[e];
          wneed[e]  = need_row[e] - req_q[e];
        end
      end
    end else if (rollback) begin
      we     = '1;
      walloc = save_alloc_q;
      wneed  = save_need_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_alloc_q <= mem_alloc[raddr];
    rd_need_q  <= mem_need[raddr];
    for (int e = 0; e < MAX_RES; e++) begin
      if (we[e]) begin
        mem_alloc[waddr][e] <= walloc[e];
        mem_need[waddr][e]  <= wneed[e];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PROCS; i++) valid_q[i] <= '0;
      rd_valid_q <= '0;
    end else begin
      rd_valid_q <= valid_q[raddr];
      valid_q[waddr] <= valid_q[waddr] | we;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < MAX_RES; e++) begin
        avail_q[e] <= '0;
        req_q[e]   <= '0;
        work_q[e]  <= '0;
      end
      marks_q    <= '0;
      done_q     <= '0;
      progress_q <= 1'b0;
      p_q        <= '0;
      proc_q     <= '0;
      query_q    <= 1'b0;
      status_q   <= STS_ACCEPTED;
      count_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        proc_q   <= process_i;
        query_q  <= (mode_i == MODE_QUERY);
        count_q  <= '0;
        status_q <= (mode_i == MODE_LOAD_CLAIM && !load_ok) ? STS_BAD_LOAD : STS_ACCEPTED;
        if (mode_i == MODE_LOAD_AVAIL) avail_q[resource_i] <= amount_i;
        if (mode_i == MODE_REQUEST) req_q[resource_i] <= amount_i;
      end
      if (cmd_i.check) begin
        save_alloc_q <= alloc_row;
        save_need_q  <= need_row;
        if (req_ok) begin
          for (int e = 0; e < MAX_RES; e++)
            if (in_use[e]) avail_q[e] <= avail_q[e] - req_q[e];
        end else begin
          status_q <= STS_REJ_LIMIT;
          for (int e = 0; e < MAX_RES; e++) req_q[e] <= '0;
        end
      end
      if (cmd_i.sw_init) begin
        for (int e = 0; e < MAX_RES; e++) work_q[e] <= WORK_WIDTH'(avail_q[e]);
        marks_q    <= '0;
        done_q     <= '0;
        progress_q <= 1'b0;
        p_q        <= '0;
      end
      if (cmd_i.sw_cmp) begin
        if (fits) begin
          for (int e = 0; e < MAX_RES; e++)
            if (in_use[e]) work_q[e] <= work_q[e] + WORK_WIDTH'(alloc_row[e]);
          marks_q[p_q] <= 1'b1;
        end
        done_q <= done_d;
        // wrap to the first process at the end of a pass
        if (sts_o.last_proc) begin
          p_q        <= '0;
          progress_q <= 1'b0;
        end else begin
          p_q        <= p_q + 1'b1;
          progress_q <= progress_d;
        end
      end
      if (cmd_i.sw_end) begin
        count_q <= done_q;
        if (query_q) begin
          status_q <= (done_q == np_i) ? STS_SAFE : STS_UNSAFE;
        end else begin
          status_q <= (done_q == np_i) ? STS_GRANTED : STS_REJ_UNSAFE;
          for (int e = 0; e < MAX_RES; e++) begin
            req_q[e] <= '0;
            if (rollback && in_use[e]) avail_q[e] <= avail_q[e] + req_q[e];
          end
        end
      end
    end
  end

  assign status_o = status_q;
  assign count_o  = count_q;

endmodule

>>> sv/bankers_safety_check.sv
// ----------------------------------------------------------------------------
// bankers_safety_check
// Deadlock-avoidance engine: loads, requests with tentative apply and
// rollback, and safety sweeps over the allocation and need stores.
//
//  channel   dir  signals                      content
//  s_axis    in   tvalid/tready/tdata/tuser/   one command item
//                 tlast
//  m_axis    out  tvalid/tready/tdata          status and finished count
//  apb       in   psel/penable/pwrite/paddr/   processes_in_use (0x0),
//                 pwdata/prdata/pready         resources_in_use (0x4)
//
// Loads and plain request elements go straight to the result. A last request
// element is checked first, then swept, or goes straight to the result when
// it is rejected; a query goes straight to the sweep. The sweep runs an
// init step, then a row read and a compare per process over up to np passes,
// then an end step; the allocation/need store has one shared row read port.
// Stores read as zero after reset through per-entry valid bits; no clear pass.
// A result waits in the output register; the next item is taken meanwhile,
// and the engine holds only when a second result finds that register full.
// ----------------------------------------------------------------------------
module bankers_safety_check import bsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] process, [5:3] resource, [13:6] amount, [21:14] held_amount
  input  logic [23:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [6:3] finished_count
  output logic [7:0]  m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFG_W-1:0] procs_q, res_q, np, nr;
  logic             out_valid_q, out_free, out_load;
  logic [2:0]       out_status_q, dp_status;
  logic [3:0]       out_count_q, dp_count;
  cmd_t             cmd;
  sts_t             sts;

  assign pready = 1'b1;
  assign prdata = {28'b0, (paddr[2] == REG_RES) ? res_q : procs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      procs_q <= CFG_W'(8);
      res_q   <= CFG_W'(8);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_PROCS) procs_q <= pwdata[CFG_W-1:0];
      else res_q <= pwdata[CFG_W-1:0];
    end
  end

  assign np = (procs_q > CFG_W'(MAX_PROCS)) ? CFG_W'(MAX_PROCS) : procs_q;
  assign nr = (res_q > CFG_W'(MAX_RES)) ? CFG_W'(MAX_RES) : res_q;

  assign out_free = !out_valid_q || m_axis_tready;

  bsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_last_i  (s_axis_tlast),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready),
    .out_load_o (out_load)
  );

  bsc_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .mode_i     (s_axis_tuser),
    .process_i  (s_axis_tdata[2:0]),
    .resource_i (s_axis_tdata[5:3]),
    .amount_i   (s_axis_tdata[13:6]),
    .held_i     (s_axis_tdata[21:14]),
    .np_i       (np),
    .nr_i       (nr),
    .sts_o      (sts),
    .status_o   (dp_status),
    .count_o    (dp_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= dp_status;
      out_count_q  <= dp_count;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_status_q};

endmodule
